### rtl/apif_pkg.sv
// ----------------------------------------------------------------------------
// All-pole IIR filter package
// Shared constants, field codes, state encoding and the control structs that
// pass between the sequencer and the multiply-round unit.
// ----------------------------------------------------------------------------
`default_nettype none

package apif_pkg;

    // Default sizes for the top-level parameters.
    localparam int MAX_ORDER_DEF    = 32;
    localparam int SAMPLE_WIDTH_DEF = 24;
    localparam int COEF_WIDTH_DEF   = 24;

    // Delay words are always 32-bit; coefficients carry four integer bits.
    localparam int DELAY_WIDTH   = 32;
    localparam int COEF_INT_BITS = 4;
    // Width of a rounded product of a coefficient and a delay-width operand.
    localparam int RND_W         = DELAY_WIDTH + COEF_INT_BITS + 1;

    // Field widths fixed by the item format.
    localparam int MODE_W     = 2;
    localparam int COEF_IDX_W = 6;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 6;

    typedef enum logic [MODE_W-1:0] {
        MODE_SAMPLE = 2'd0,
        MODE_COEF   = 2'd1,
        MODE_CLEAR  = 2'd2
    } mode_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ORDER      = 2'd0,
        CFG_TRANSPOSED = 2'd1
    } cfg_reg_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_GAIN,
        ST_WAIT,
        ST_TAPS,
        ST_DRAIN,
        ST_FINISH
    } state_t;

    // Operation entering the multiply-round unit.
    typedef struct packed {
        logic vld;
        logic gain;
    } mac_ctl_t;

    // Status of the multiply-round unit.
    typedef struct packed {
        logic vld;   // result stage holds a finished product
        logic gain;  // that product is the gained input
        logic clip;  // the feedback product was clipped to 32 bits
        logic busy;  // the product stage is occupied
    } mac_stat_t;

endpackage

`default_nettype wire

### rtl/apif_mac.sv
// ----------------------------------------------------------------------------
// Shared multiply-round unit
// Two-stage pipeline: a signed coefficient times a 32-bit operand, then
// round half up to an integer and clip to a 32-bit term.
// ----------------------------------------------------------------------------
`default_nettype none

module apif_mac
    import apif_pkg::*;
#(
    parameter int COEF_WIDTH = COEF_WIDTH_DEF
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire mac_ctl_t                        ctl,
    input  wire logic signed [COEF_WIDTH-1:0]    coef,
    input  wire logic signed [DELAY_WIDTH-1:0]   opd,
    output mac_stat_t                            stat,
    output logic signed      [RND_W-1:0]         rnd_out,
    output logic signed      [DELAY_WIDTH-1:0]   term_out
);

    localparam int FRAC = COEF_WIDTH - COEF_INT_BITS;
    localparam int PW   = COEF_WIDTH + DELAY_WIDTH;
    localparam logic signed [PW:0] HALF = (PW+1)'(64'd1 << (FRAC - 1));
    localparam logic signed [DELAY_WIDTH-1:0] TMAX = {1'b0, {(DELAY_WIDTH-1){1'b1}}};
    localparam logic signed [DELAY_WIDTH-1:0] TMIN = {1'b1, {(DELAY_WIDTH-1){1'b0}}};

    mac_ctl_t                       ctl1_reg;
    mac_ctl_t                       ctl2_reg;
    logic signed [PW-1:0]           prod_reg;
    logic signed [PW:0]             rsum;
    logic signed [RND_W-1:0]        rnd;
    logic                           rclip;
    logic signed [DELAY_WIDTH-1:0]  rterm;
    logic signed [RND_W-1:0]        rnd_reg;
    logic signed [DELAY_WIDTH-1:0]  term_reg;
    logic                           clip_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctl1_reg <= '0;
            ctl2_reg <= '0;
        end else begin
            ctl1_reg <= ctl;
            ctl2_reg <= ctl1_reg;
        end
    end

    // Floor of (p + half) / 2^FRAC is an arithmetic shift after the add.
    always_comb begin
        rsum  = (PW+1)'(prod_reg) + HALF;
        rnd   = rsum[PW:FRAC];
        rclip = !((&rnd[RND_W-1:DELAY_WIDTH-1]) || !(|rnd[RND_W-1:DELAY_WIDTH-1]));
        if (rclip) begin
            rterm = rnd[RND_W-1] ? TMIN : TMAX;
        end else begin
            rterm = rnd[DELAY_WIDTH-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        prod_reg <= PW'(coef) * PW'(opd);
        rnd_reg  <= rnd;
        term_reg <= rterm;
        clip_reg <= rclip && !ctl1_reg.gain;
    end

    assign stat.vld  = ctl2_reg.vld;
    assign stat.gain = ctl2_reg.gain;
    assign stat.clip = clip_reg;
    assign stat.busy = ctl1_reg.vld;
    assign rnd_out   = rnd_reg;
    assign term_out  = term_reg;

endmodule

`default_nettype wire

### rtl/all_pole_iir_filter.sv
// ----------------------------------------------------------------------------
// All-pole IIR filter
// y = K*x - sum a[m]*y[n-m], direct or transposed form, one shared MAC.
// ----------------------------------------------------------------------------
// Requests arrive on the s_ stream; s_tuser carries the mode. A sample request
// gives one result on the m_ stream; a coefficient request writes K or a[m]
// and a clear request zeroes the delay line, both in the cycle they are taken
// and with no result. Registers (order, transposed) are written through the
// cfg_ port; the user must write them only while the filter is idle, which
// the block does not enforce. A change of order clears the delay line. A
// sample takes one gain issue, one issue per tap through the shared
// multiply-round unit, a pipeline drain and a finish step; transposed form
// adds a wait for the transposed sum. The unit takes one operation per cycle;
// the sample path is a four-stage pipeline (memory read, multiply, round,
// add). s_tready is high only between samples. The result sits in an
// output register, so a new request is taken while it waits; if the receiver
// still holds the previous result the finish cycle repeats until it is taken.
// Reset empties the pipeline, sets both registers to zero and marks every
// coefficient and delay word as zero through valid bits, with no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module all_pole_iir_filter
    import apif_pkg::*;
#(
    parameter int MAX_ORDER    = MAX_ORDER_DEF,
    parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
    parameter int COEF_WIDTH   = COEF_WIDTH_DEF,
    localparam int S_TDATA_W   = ((SAMPLE_WIDTH + COEF_IDX_W + COEF_WIDTH + 7) / 8) * 8,
    localparam int M_TDATA_W   = ((SAMPLE_WIDTH + 7) / 8) * 8
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    // sample_in, coef_index, coef_value, zero fill
    input  wire logic [S_TDATA_W-1:0]   s_tdata,
    // mode
    input  wire logic [MODE_W-1:0]      s_tuser,
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    // sample_out, zero fill
    output logic [M_TDATA_W-1:0]        m_tdata,
    // saturated
    output logic [0:0]                  m_tuser,
    input  wire logic                   cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_wdata
);

    localparam int DW     = DELAY_WIDTH;
    localparam int ORD_W  = $clog2(MAX_ORDER + 1);
    localparam int CA_W   = $clog2(MAX_ORDER + 1);
    localparam int DA_W   = (MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1;
    localparam int ACC_W  = RND_W + $clog2(MAX_ORDER + 1) + 1;
    localparam int IDX_LO = SAMPLE_WIDTH;
    localparam int CV_LO  = SAMPLE_WIDTH + COEF_IDX_W;
    localparam logic signed [DW-1:0] DMAX = {1'b0, {(DW-1){1'b1}}};
    localparam logic signed [DW-1:0] DMIN = {1'b1, {(DW-1){1'b0}}};
    localparam logic signed [SAMPLE_WIDTH-1:0] YMAX = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
    localparam logic signed [SAMPLE_WIDTH-1:0] YMIN = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};

    // Input fields.
    mode_t                           s_mode;
    logic signed [SAMPLE_WIDTH-1:0]  s_sample;
    logic [COEF_IDX_W-1:0]           s_coef_index;
    logic signed [COEF_WIDTH-1:0]    s_coef_value;

    // Control state.
    state_t                 state_reg, state_next;
    logic [ORD_W-1:0]       tap_cnt_reg, tap_cnt_next;
    logic                   wait_cnt_reg, wait_cnt_next;
    logic [ORD_W-1:0]       order_reg;
    logic                   transposed_reg;
    logic                   use_trans_reg;
    logic [MAX_ORDER:0]     cvalid_reg;
    logic [MAX_ORDER-1:0]   dvalid_reg;
    logic                   m_tvalid_reg;
    logic                   p1_vld_reg;

    // Handshake and decode.
    logic                   in_acc;
    logic                   sample_go;
    logic                   coef_we;
    logic [CA_W-1:0]        coef_waddr;
    logic                   dly_clear;
    logic [ORD_W-1:0]       cfg_order_sat;
    logic                   out_free;
    logic                   fin_go;
    logic                   pipe_empty;

    // Issue stage.
    logic                   iss_vld;
    logic                   iss_gain;
    logic [ORD_W-1:0]       iss_m;
    logic [CA_W-1:0]        iss_caddr;
    logic [DA_W-1:0]        iss_daddr;
    logic                   iss_drd;

    // Memories and read stage.
    logic [COEF_WIDTH-1:0]  coef_mem [MAX_ORDER+1];
    logic signed [DW-1:0]   dly_mem  [MAX_ORDER];
    logic [COEF_WIDTH-1:0]  coef_rd_reg;
    logic                   coef_ok_reg;
    logic signed [DW-1:0]   dly_rd_reg;
    logic                   dly_ok_reg;
    logic                   p1_gain_reg;
    logic [ORD_W-1:0]       p1_m_reg;
    logic signed [COEF_WIDTH-1:0] coef_val;
    logic signed [DW-1:0]   dly_val;
    logic signed [DW-1:0]   mac_opd;

    // Stages running beside the multiply-round unit.
    logic [ORD_W-1:0]       p2_m_reg, p3_m_reg;
    logic signed [DW-1:0]   p2_dly_reg, p3_dly_reg;
    mac_ctl_t               mac_ctl;
    mac_stat_t              mac_stat;
    logic signed [RND_W-1:0] mac_rnd;
    logic signed [DW-1:0]   mac_term;

    // Accumulate stage.
    logic signed [ACC_W-1:0] acc_reg;
    logic signed [DW-1:0]    s_reg;
    logic signed [SAMPLE_WIDTH-1:0] sample_reg;
    logic                    flag_reg;
    logic signed [RND_W:0]   gsum;
    logic                    gsum_clip;
    logic signed [DW-1:0]    gsum_sat;
    logic signed [DW:0]      tsum;
    logic                    tsum_clip;
    logic signed [DW-1:0]    tsum_sat;
    logic                    s4_clip;

    // Finish.
    logic                    acc_clip;
    logic signed [DW-1:0]    s_fin;
    logic                    s_fin_clip;
    logic                    y_clip;
    logic signed [SAMPLE_WIDTH-1:0] y_fin;
    logic [SAMPLE_WIDTH-1:0] y_out_reg;
    logic                    sat_out_reg;

    // Delay line write port.
    logic                    dly_wr_en;
    logic [DA_W-1:0]         dly_wr_addr;
    logic signed [DW-1:0]    dly_wr_data;

    assign s_mode       = mode_t'(s_tuser);
    assign s_sample     = s_tdata[SAMPLE_WIDTH-1:0];
    assign s_coef_index = s_tdata[IDX_LO +: COEF_IDX_W];
    assign s_coef_value = s_tdata[CV_LO +: COEF_WIDTH];

    assign in_acc     = s_tvalid && s_tready;
    assign sample_go  = in_acc && (s_mode == MODE_SAMPLE);
    assign coef_we    = in_acc && (s_mode == MODE_COEF) && (int'(s_coef_index) <= MAX_ORDER);
    assign coef_waddr = CA_W'(s_coef_index);
    assign out_free   = !m_tvalid_reg || m_tready;
    assign pipe_empty = !p1_vld_reg && !mac_stat.busy && !mac_stat.vld;

    assign cfg_order_sat = (int'(cfg_wdata) > MAX_ORDER) ? ORD_W'(MAX_ORDER) : ORD_W'(cfg_wdata);
    assign dly_clear = (in_acc && (s_mode == MODE_CLEAR)) ||
                       (cfg_wr_en && (cfg_reg_t'(cfg_index) == CFG_ORDER) &&
                        (cfg_order_sat != order_reg));

    // ------------------------------------------------------------------
    // Sequencer: next state.
    // ------------------------------------------------------------------
    always_comb begin
        state_next    = state_reg;
        tap_cnt_next  = tap_cnt_reg;
        wait_cnt_next = wait_cnt_reg;
        case (state_reg)
            ST_IDLE: begin
                if (sample_go) begin
                    state_next = ST_GAIN;
                end
            end
            ST_GAIN: begin
                if (use_trans_reg) begin
                    tap_cnt_next  = ORD_W'(1);
                    wait_cnt_next = 1'b1;
                    state_next    = ST_WAIT;
                end else begin
                    tap_cnt_next = order_reg;
                    state_next   = (order_reg == '0) ? ST_DRAIN : ST_TAPS;
                end
            end
            ST_WAIT: begin
                // Taps need the transposed sum from the gain issue, so they wait
                // for it to leave the pipeline.
                wait_cnt_next = 1'b0;
                if (!wait_cnt_reg) begin
                    state_next = ST_TAPS;
                end
            end
            ST_TAPS: begin
                if (use_trans_reg) begin
                    tap_cnt_next = tap_cnt_reg + ORD_W'(1);
                    if (tap_cnt_reg == order_reg) begin
                        state_next = ST_DRAIN;
                    end
                end else begin
                    tap_cnt_next = tap_cnt_reg - ORD_W'(1);
                    if (tap_cnt_reg == ORD_W'(1)) begin
                        state_next = ST_DRAIN;
                    end
                end
            end
            ST_DRAIN: begin
                if (pipe_empty) begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Sequencer: outputs.
    // ------------------------------------------------------------------
    always_comb begin
        s_tready  = 1'b0;
        iss_vld   = 1'b0;
        iss_gain  = 1'b0;
        iss_m     = '0;
        iss_caddr = '0;
        iss_daddr = '0;
        iss_drd   = 1'b0;
        fin_go    = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
            end
            ST_GAIN: begin
                // The transposed sum also needs the head of the delay line.
                iss_vld  = 1'b1;
                iss_gain = 1'b1;
                iss_drd  = use_trans_reg;
            end
            ST_TAPS: begin
                iss_vld   = 1'b1;
                iss_m     = tap_cnt_reg;
                iss_caddr = CA_W'(tap_cnt_reg);
                if (use_trans_reg) begin
                    iss_daddr = DA_W'(tap_cnt_reg);
                    iss_drd   = (tap_cnt_reg < order_reg);
                end else begin
                    iss_daddr = DA_W'(tap_cnt_reg - ORD_W'(1));
                    iss_drd   = 1'b1;
                end
            end
            ST_FINISH: begin
                fin_go = out_free;
            end
            default: begin
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Control registers.
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            tap_cnt_reg    <= '0;
            wait_cnt_reg   <= 1'b0;
            order_reg      <= '0;
            transposed_reg <= 1'b0;
            use_trans_reg  <= 1'b0;
            cvalid_reg     <= '0;
            dvalid_reg     <= '0;
            m_tvalid_reg   <= 1'b0;
            p1_vld_reg     <= 1'b0;
        end else begin
            state_reg    <= state_next;
            tap_cnt_reg  <= tap_cnt_next;
            wait_cnt_reg <= wait_cnt_next;
            p1_vld_reg   <= iss_vld;
            if (cfg_wr_en) begin
                case (cfg_reg_t'(cfg_index))
                    CFG_ORDER:      order_reg      <= cfg_order_sat;
                    CFG_TRANSPOSED: transposed_reg <= cfg_wdata[0];
                    default: begin
                    end
                endcase
            end
            if (sample_go) begin
                use_trans_reg <= transposed_reg && (order_reg != '0);
            end
            if (coef_we) begin
                cvalid_reg[coef_waddr] <= 1'b1;
            end
            if (dly_clear) begin
                dvalid_reg <= '0;
            end else if (dly_wr_en) begin
                dvalid_reg[dly_wr_addr] <= 1'b1;
            end
            if (fin_go) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Coefficient and delay memories, registered reads.
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (coef_we) begin
            coef_mem[coef_waddr] <= s_coef_value;
        end
        coef_rd_reg <= coef_mem[iss_caddr];
    end

    always_ff @(posedge aclk) begin
        if (dly_wr_en) begin
            dly_mem[dly_wr_addr] <= dly_wr_data;
        end
        dly_rd_reg <= dly_mem[iss_daddr];
    end

    // Words never written since reset (coefficients) or since the last clear (delay words) read as zero.
    always_ff @(posedge aclk) begin
        coef_ok_reg <= cvalid_reg[iss_caddr];
        dly_ok_reg  <= iss_drd && dvalid_reg[iss_daddr];
        p1_gain_reg <= iss_gain;
        p1_m_reg    <= iss_m;
    end

    assign coef_val = coef_ok_reg ? coef_rd_reg : '0;
    assign dly_val  = dly_ok_reg ? dly_rd_reg : '0;

    always_comb begin
        if (p1_gain_reg) begin
            mac_opd = DW'(sample_reg);
        end else if (use_trans_reg) begin
            mac_opd = s_reg;
        end else begin
            mac_opd = dly_val;
        end
    end

    assign mac_ctl.vld  = p1_vld_reg;
    assign mac_ctl.gain = p1_gain_reg;

    apif_mac #(
        .COEF_WIDTH (COEF_WIDTH)
    ) u_mac (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctl      (mac_ctl),
        .coef     (coef_val),
        .opd      (mac_opd),
        .stat     (mac_stat),
        .rnd_out  (mac_rnd),
        .term_out (mac_term)
    );

    always_ff @(posedge aclk) begin
        p2_m_reg   <= p1_m_reg;
        p2_dly_reg <= dly_val;
        p3_m_reg   <= p2_m_reg;
        p3_dly_reg <= p2_dly_reg;
    end

    // ------------------------------------------------------------------
    // Accumulate stage.
    // ------------------------------------------------------------------
    always_comb begin
        gsum      = (RND_W+1)'(mac_rnd) - (RND_W+1)'(p3_dly_reg);
        gsum_clip = !((&gsum[RND_W:DW-1]) || !(|gsum[RND_W:DW-1]));
        if (gsum_clip) begin
            gsum_sat = gsum[RND_W] ? DMIN : DMAX;
        end else begin
            gsum_sat = gsum[DW-1:0];
        end
        tsum      = (DW+1)'(p3_dly_reg) + (DW+1)'(mac_term);
        tsum_clip = (tsum[DW] != tsum[DW-1]);
        if (tsum_clip) begin
            tsum_sat = tsum[DW] ? DMIN : DMAX;
        end else begin
            tsum_sat = tsum[DW-1:0];
        end
        s4_clip = mac_stat.vld &&
                  (mac_stat.clip || (use_trans_reg && (mac_stat.gain ? gsum_clip : tsum_clip)));
    end

    // Finish: in direct form clip the sum to a delay word, then clip to the output width.
    always_comb begin
        acc_clip = !((&acc_reg[ACC_W-1:DW-1]) || !(|acc_reg[ACC_W-1:DW-1]));
        if (use_trans_reg) begin
            s_fin      = s_reg;
            s_fin_clip = 1'b0;
        end else if (acc_clip) begin
            s_fin      = acc_reg[ACC_W-1] ? DMIN : DMAX;
            s_fin_clip = 1'b1;
        end else begin
            s_fin      = acc_reg[DW-1:0];
            s_fin_clip = 1'b0;
        end
        y_clip = !((&s_fin[DW-1:SAMPLE_WIDTH-1]) || !(|s_fin[DW-1:SAMPLE_WIDTH-1]));
        if (y_clip) begin
            y_fin = s_fin[DW-1] ? YMIN : YMAX;
        end else begin
            y_fin = s_fin[SAMPLE_WIDTH-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (sample_go) begin
            sample_reg <= s_sample;
            flag_reg   <= 1'b0;
        end else begin
            flag_reg <= flag_reg || s4_clip;
        end
        if (mac_stat.vld && !use_trans_reg) begin
            if (mac_stat.gain) begin
                acc_reg <= ACC_W'(mac_rnd);
            end else begin
                acc_reg <= acc_reg - ACC_W'(mac_term);
            end
        end
        if (mac_stat.vld && mac_stat.gain && use_trans_reg) begin
            s_reg <= gsum_sat;
        end
        if (fin_go) begin
            y_out_reg   <= y_fin;
            sat_out_reg <= flag_reg || s_fin_clip || y_clip;
        end
    end

    // ------------------------------------------------------------------
    // Delay line write port: the direct-form shift, the transposed update
    // and the new head word in direct form never meet in one cycle.
    // ------------------------------------------------------------------
    always_comb begin
        dly_wr_en   = 1'b0;
        dly_wr_addr = '0;
        dly_wr_data = '0;
        if (p1_vld_reg && !p1_gain_reg && !use_trans_reg && (p1_m_reg < order_reg)) begin
            dly_wr_en   = 1'b1;
            dly_wr_addr = DA_W'(p1_m_reg);
            dly_wr_data = dly_val;
        end else if (mac_stat.vld && !mac_stat.gain && use_trans_reg) begin
            dly_wr_en   = 1'b1;
            dly_wr_addr = DA_W'(p3_m_reg - ORD_W'(1));
            dly_wr_data = tsum_sat;
        end else if (fin_go && !use_trans_reg && (order_reg != '0)) begin
            dly_wr_en   = 1'b1;
            dly_wr_addr = '0;
            dly_wr_data = s_fin;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = M_TDATA_W'(y_out_reg);
    assign m_tuser  = sat_out_reg;

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------
    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> (!p1_vld_reg && !mac_stat.busy && !mac_stat.vld))
        else $error("request taken while the pipeline still holds work");

    a_no_write_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE) |-> !dly_wr_en)
        else $error("delay line written while idle");

    a_result_from_finish: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid_reg) |-> $past(state_reg == ST_FINISH))
        else $error("result raised outside the finish step");

    a_tap_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_TAPS) |-> ((tap_cnt_reg != '0) && (tap_cnt_reg <= order_reg)))
        else $error("tap counter outside the filter order");

endmodule

`default_nettype wire
